// ----- hdl/mdw_pkg.sv -----
// Shared widths and stage type for the wide multiply-divide core.
`timescale 1ns / 1ps
package mdw_pkg;
	localparam int unsigned WordW = 64;
	localparam int unsigned HalfW = WordW / 2;
	localparam int unsigned ProdW = 2 * WordW;
	localparam int unsigned DivSteps = ProdW;

	typedef struct packed {
		logic             vld;
		logic             dz;
		logic [WordW-1:0] dvs;
		logic [WordW-1:0] rem;
		logic [ProdW-1:0] num;
	} mdw_div_t;
endpackage

// ----- hdl/mdw_mul.sv -----
// Three-stage 64x64 to 128-bit multiplier built from 32x32 partial products.
`timescale 1ns / 1ps
module mdw_mul
	import mdw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [WordW-1:0] factor_a,
	input  logic [WordW-1:0] factor_b,
	input  logic [WordW-1:0] divisor,
	output mdw_div_t         out
);
	logic             vld_s1, vld_s2, vld_s3;
	logic [WordW-1:0] a_s1, b_s1, d_s1, d_s2, d_s3;
	logic [WordW-1:0] p00_s2, p01_s2, p10_s2, p11_s2;
	logic [ProdW-1:0] prod_s3;
	logic [HalfW+1:0] mid;
	logic [WordW-1:0] hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_comb begin
		mid = {2'b00, p00_s2[WordW-1:HalfW]} + {2'b00, p01_s2[HalfW-1:0]}
			+ {2'b00, p10_s2[HalfW-1:0]};
		hi = p11_s2 + {{HalfW{1'b0}}, p01_s2[WordW-1:HalfW]}
			+ {{HalfW{1'b0}}, p10_s2[WordW-1:HalfW]}
			+ {{(WordW-2){1'b0}}, mid[HalfW+1:HalfW]};
	end

	always_ff @(posedge clk) begin
		a_s1    <= factor_a;
		b_s1    <= factor_b;
		d_s1    <= divisor;
		p00_s2  <= {{HalfW{1'b0}}, a_s1[HalfW-1:0]} * {{HalfW{1'b0}}, b_s1[HalfW-1:0]};
		p01_s2  <= {{HalfW{1'b0}}, a_s1[HalfW-1:0]} * {{HalfW{1'b0}}, b_s1[WordW-1:HalfW]};
		p10_s2  <= {{HalfW{1'b0}}, a_s1[WordW-1:HalfW]} * {{HalfW{1'b0}}, b_s1[HalfW-1:0]};
		p11_s2  <= {{HalfW{1'b0}}, a_s1[WordW-1:HalfW]} * {{HalfW{1'b0}}, b_s1[WordW-1:HalfW]};
		d_s2    <= d_s1;
		prod_s3 <= {hi, mid[HalfW-1:0], p00_s2[HalfW-1:0]};
		d_s3    <= d_s2;
	end

	always_comb begin
		out.vld = vld_s3;
		out.dz  = (d_s3 == '0);
		out.dvs = d_s3;
		out.rem = '0;
		out.num = prod_s3;
	end
endmodule

// ----- hdl/mdw_div_step.sv -----
// One registered restoring-division step: one quotient bit per stage.
`timescale 1ns / 1ps
module mdw_div_step
	import mdw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mdw_div_t in,
	output mdw_div_t out
);
	logic [WordW:0] sh;
	logic [WordW:0] diff;
	logic           ge;
	logic           vld_s1;
	mdw_div_t       dat_s1;

	always_comb begin
		sh   = {in.rem, in.num[ProdW-1]};
		diff = sh - {1'b0, in.dvs};
		ge   = (sh >= {1'b0, in.dvs});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in.vld;
		end
	end

	always_ff @(posedge clk) begin
		dat_s1.vld <= 1'b0;
		dat_s1.dz  <= in.dz;
		dat_s1.dvs <= in.dvs;
		dat_s1.rem <= ge ? diff[WordW-1:0] : sh[WordW-1:0];
		dat_s1.num <= {in.num[ProdW-2:0], ge};
	end

	always_comb begin
		out     = dat_s1;
		out.vld = vld_s1;
	end
endmodule

// ----- hdl/multiply_divide_wide_core.sv -----
// Top level: pipelined 64x64 multiply followed by a 128/64 divide.
//
//  channel  | strobe        | payload
//  ---------+---------------+-----------------------------------------------
//  command  | start / busy  | factor_a, factor_b, divisor
//  result   | done          | quotient, quotient_overflow, divide_by_zero
//
// One beat enters per cycle; busy is always low.
// The path runs through 3 multiplier stages, 128 divide stages and 1 output register.
// The divide chain sets the depth: one quotient bit per stage.
// Reset clears only the valid bits; the receiver cannot stall.
`timescale 1ns / 1ps
module multiply_divide_wide_core
	import mdw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [WordW-1:0] factor_a,
	input  logic [WordW-1:0] factor_b,
	input  logic [WordW-1:0] divisor,
	output logic             done,
	output logic [WordW-1:0] quotient,
	output logic             quotient_overflow,
	output logic             divide_by_zero
);
	mdw_div_t chain [DivSteps+1];
	logic             done_q;
	logic [WordW-1:0] quot_q;
	logic             ovf_q;
	logic             dz_q;
	mdw_div_t         last;

	assign busy = 1'b0;

	mdw_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start),
		.factor_a (factor_a),
		.factor_b (factor_b),
		.divisor  (divisor),
		.out      (chain[0])
	);

	for (genvar i = 0; i < DivSteps; i++) begin : g_div
		mdw_div_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.in     (chain[i]),
			.out    (chain[i+1])
		);
	end

	assign last = chain[DivSteps];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last.vld;
		end
	end

	always_ff @(posedge clk) begin
		quot_q <= last.dz ? '0 : last.num[WordW-1:0];
		ovf_q  <= !last.dz && (last.num[ProdW-1:WordW] != '0);
		dz_q   <= last.dz;
	end

	assign done              = done_q;
	assign quotient          = quot_q;
	assign quotient_overflow = ovf_q;
	assign divide_by_zero    = dz_q;
endmodule
